// ===== src/fh64_pkg.sv =====
// Shared types, constants and mixing helpers for the fasthash64 stream block.
// Used by every module of the block and by its checker. No dependencies.
package fh64_pkg;

    localparam logic [63:0] HASH_M   = 64'h8803_55f2_1e6d_1965;
    localparam logic [63:0] MIX_K    = 64'h2127_599b_f432_5c37;
    localparam int          MIX_SH1  = 23;
    localparam int          MIX_SH2  = 47;
    localparam logic [63:0] SEED_RST = 64'd271;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic [31:0] message_length;
        logic        first_word;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [63:0] hash64;
        logic [31:0] hash32;
    } t_out_item;

    typedef struct packed {
        logic [63:0] word;
        logic        absorb;
        logic [31:0] length;
        logic        first;
        logic        last;
    } t_job;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

    function automatic logic [63:0] mix_pre(input logic [63:0] x);
        mix_pre = x ^ (x >> MIX_SH1);
    endfunction

    function automatic logic [63:0] mix_post(input logic [63:0] x);
        mix_post = x ^ (x >> MIX_SH2);
    endfunction

endpackage

// ===== src/fasthash64_stream.sv =====
// fasthash64 stream hasher, top level: seed register, front end, job queue, back end.
// Depends on fh64_pkg, fh64_front, fh64_queue and fh64_back.
//
// Hashes a message given as little-endian 64-bit words and returns the 64-bit hash
// and its 32-bit fold on the word marked last. The front end pads each word and
// queues it at once, so the input stays ready while the queue has room. The back
// end runs the words through one shared 32x32 multiplier, each 64-bit product
// taking an operand load, then three partial products. The seed port is always
// ready; the user must write it only while no message is in flight, as the
// block itself does not enforce this.
module fasthash64_stream
    import fh64_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_seed;
    logic        w_push;
    t_job        w_push_job;
    logic        w_full;
    logic        w_pop;
    logic        w_empty;
    t_job        w_head_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RST;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    fh64_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_full     (w_full)
    );

    fh64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    fh64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (r_seed),
        .i_empty     (w_empty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== src/fh64_front.sv =====
// Front end: takes input words, pads partial words and classifies them into jobs.
// Depends on fh64_pkg.
module fh64_front
    import fh64_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_push,
    output t_job     o_job,
    input  logic     i_full
);

    logic [63:0] w_word;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (i_in_item.valid_bytes > 4'(i)) begin
                w_word[i*8 +: 8] = i_in_item.data_word[i*8 +: 8];
            end else begin
                w_word[i*8 +: 8] = 8'h00;
            end
        end
    end

    assign o_in_ready   = !i_full;
    assign o_push       = i_in_valid && !i_full;
    assign o_job.word   = w_word;
    assign o_job.absorb = (i_in_item.valid_bytes != 4'd0);
    assign o_job.length = i_in_item.message_length;
    assign o_job.first  = i_in_item.first_word;
    assign o_job.last   = i_in_item.last_word;

endmodule

// ===== src/fh64_queue.sv =====
// Short job queue between the front end and the hashing back end.
// Depends on fh64_pkg.
module fh64_queue
    import fh64_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/fh64_mul.sv =====
// Iterative 64x64 multiplier giving the low 64 bits, one 32x32 partial product a cycle.
// Depends on fh64_pkg.
module fh64_mul
    import fh64_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic [63:0] n_acc;

    always_comb begin
        case (r_step)
            2'd0: begin
                w_ma = r_a[31:0];
                w_mb = r_b[31:0];
            end
            2'd1: begin
                w_ma = r_a[31:0];
                w_mb = r_b[63:32];
            end
            default: begin
                w_ma = r_a[63:32];
                w_mb = r_b[31:0];
            end
        endcase
        w_prod = 64'(w_ma) * 64'(w_mb);
        if (r_step == 2'd0) begin
            n_acc = w_prod;
        end else begin
            n_acc = r_acc + {w_prod[31:0], 32'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_step <= 2'd0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy && !i_req.start) begin
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

// ===== src/fh64_back.sv =====
// Back end: sequences the seed, absorb and finalise steps of each job over the
// shared multiplier and holds the result word. Depends on fh64_pkg and fh64_mul.
module fh64_back
    import fh64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_seed,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_HEAD = 11'b000_0000_0010,
        S_LEN  = 11'b000_0000_0100,
        S_BODY = 11'b000_0000_1000,
        S_MIXW = 11'b000_0001_0000,
        S_H1   = 11'b000_0010_0000,
        S_H2   = 11'b000_0100_0000,
        S_TAIL = 11'b000_1000_0000,
        S_F1   = 11'b001_0000_0000,
        S_F2   = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    t_job        r_job;
    t_job        n_job;
    logic [63:0] r_rh;
    logic [63:0] n_rh;
    logic [63:0] r_rh32;
    logic [63:0] n_rh32;
    logic [63:0] r_mv;
    logic [63:0] n_mv;
    logic [63:0] r_h64;
    logic [63:0] n_h64;
    logic [31:0] r_h32;
    logic [31:0] n_h32;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    t_mul_req    w_req;
    t_mul_rsp    w_rsp;
    logic [63:0] w_post;

    fh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_post = mix_post(w_rsp.p);
    assign o_pop  = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_rh        = r_rh;
        n_rh32      = r_rh32;
        n_mv        = r_mv;
        n_h64       = r_h64;
        n_h32       = r_h32;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_req       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_job   = i_job;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_job.first) begin
                    w_req.start = 1'b1;
                    w_req.a     = {32'h0, r_job.length};
                    w_req.b     = HASH_M;
                    n_state     = S_LEN;
                end else begin
                    n_state = S_BODY;
                end
            end
            S_LEN: begin
                if (w_rsp.done) begin
                    n_rh    = i_seed ^ w_rsp.p;
                    n_rh32  = {32'h0, i_seed[31:0]} ^ w_rsp.p;
                    n_state = S_BODY;
                end
            end
            S_BODY: begin
                if (r_job.absorb) begin
                    w_req.start = 1'b1;
                    w_req.a     = mix_pre(r_job.word);
                    w_req.b     = MIX_K;
                    n_state     = S_MIXW;
                end else begin
                    n_state = S_TAIL;
                end
            end
            S_MIXW: begin
                if (w_rsp.done) begin
                    n_mv        = w_post;
                    w_req.start = 1'b1;
                    w_req.a     = r_rh ^ w_post;
                    w_req.b     = HASH_M;
                    n_state     = S_H1;
                end
            end
            S_H1: begin
                if (w_rsp.done) begin
                    n_rh        = w_rsp.p;
                    w_req.start = 1'b1;
                    w_req.a     = r_rh32 ^ r_mv;
                    w_req.b     = HASH_M;
                    n_state     = S_H2;
                end
            end
            S_H2: begin
                if (w_rsp.done) begin
                    n_rh32  = w_rsp.p;
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (r_job.last) begin
                    w_req.start = 1'b1;
                    w_req.a     = mix_pre(r_rh);
                    w_req.b     = MIX_K;
                    n_state     = S_F1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_F1: begin
                if (w_rsp.done) begin
                    n_h64       = w_post;
                    w_req.start = 1'b1;
                    w_req.a     = mix_pre(r_rh32);
                    w_req.b     = MIX_K;
                    n_state     = S_F2;
                end
            end
            S_F2: begin
                if (w_rsp.done) begin
                    n_h32   = w_post[31:0] - w_post[63:32];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out.hash64 = r_h64;
                    n_out.hash32 = r_h32;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rh        <= '0;
            r_rh32      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rh        <= n_rh;
            r_rh32      <= n_rh32;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_mv  <= n_mv;
        r_h64 <= n_h64;
        r_h32 <= n_h32;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== src/fh64_checker.sv =====
// Port-level checks for the fasthash64 stream block, bound to its top level.
// Depends on fh64_pkg and fasthash64_stream.
module fh64_checker
    import fh64_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_item,
    input logic        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result word dropped or changed while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid && o_in_ready))
        else $error("input ready fell without an accepted word");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("seed port not ready");

endmodule

bind fasthash64_stream fh64_checker u_fh64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .o_cfg_ready (o_cfg_ready)
);

// ===== sim/fh64_score_pkg.sv =====
// Scoreboard for the fasthash64 stream testbench: predicts each message hash
// from the accepted words and checks the words that come back. Needs fh64_pkg.
package fh64_score_pkg;
    import fh64_pkg::*;

    class fh64_scoreboard;
        logic [63:0] seed;
        logic [63:0] acc_full;
        logic [63:0] acc_low;
        t_out_item   expected_q[$];
        int unsigned fault_count;

        function new();
            seed = SEED_RST;
            acc_full = '0;
            acc_low = '0;
            fault_count = 0;
        endfunction

        function logic [63:0] scramble(input logic [63:0] x);
            logic [63:0] y;
            y = x ^ (x >> MIX_SH1);
            y = y * MIX_K;
            return y ^ (y >> MIX_SH2);
        endfunction

        function void set_seed(input logic [63:0] s);
            seed = s;
        endfunction

        function void note_input(input t_in_item it);
            logic [63:0] len_term;
            logic [63:0] w;
            logic [63:0] mixed;
            logic [63:0] fold;
            logic [3:0]  nb;
            t_out_item   e;
            len_term = {32'h0, it.message_length} * HASH_M;
            if (it.first_word) begin
                acc_full = seed ^ len_term;
                acc_low = {32'h0, seed[31:0]} ^ len_term;
            end
            nb = (it.valid_bytes > 4'd8) ? 4'd8 : it.valid_bytes;
            if (nb != 4'd0) begin
                w = it.data_word;
                if (nb < 4'd8) begin
                    w &= (64'h1 << {nb, 3'b000}) - 64'h1;
                end
                mixed = scramble(w);
                acc_full = (acc_full ^ mixed) * HASH_M;
                acc_low = (acc_low ^ mixed) * HASH_M;
            end
            if (it.last_word) begin
                fold = scramble(acc_low);
                e.hash64 = scramble(acc_full);
                e.hash32 = fold[31:0] - fold[63:32];
                expected_q.push_back(e);
            end
        endfunction

        function void check_result(input t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                if (fault_count < 10) begin
                    $display("unexpected word: hash64=%h hash32=%h", got.hash64, got.hash32);
                end
                fault_count++;
                return;
            end
            e = expected_q.pop_front();
            if (got.hash64 !== e.hash64 || got.hash32 !== e.hash32) begin
                if (fault_count < 10) begin
                    $display("hash differs: expected %h/%h, got %h/%h",
                             e.hash64, e.hash32, got.hash64, got.hash32);
                end
                fault_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
// Top of the fasthash64 stream testbench: clock, reset, seed writes, word
// traffic with random gaps on both sides. Needs fh64_pkg, fh64_score_pkg and the RTL.
module tb_top;
    import fh64_pkg::*;
    import fh64_score_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data;

    fh64_scoreboard sb;
    int unsigned    idle_pct;
    logic [63:0]    seed_plan [6];

    fasthash64_stream i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
        end
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item make_word(input logic [63:0] data, input logic [3:0] nb,
                                           input logic [31:0] len, input logic first,
                                           input logic last);
        t_in_item it;
        it.data_word = data;
        it.valid_bytes = nb;
        it.message_length = len;
        it.first_word = first;
        it.last_word = last;
        return it;
    endfunction

    task automatic send_word(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.note_input(it);
    endtask

    // hold off until every hash is back and the back end has drained
    task automatic write_seed(input logic [63:0] s);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= s;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.set_seed(s);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic hash_random_messages(input int unsigned budget);
        int unsigned sent;
        int unsigned nwords;
        int unsigned k;
        logic [3:0]  tail;
        logic [31:0] len;
        t_in_item    it;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 15) begin
                it = make_word(rand64(), 4'($urandom_range(15)), $urandom,
                               1'($urandom_range(1)), 1'($urandom_range(1)));
                send_word(it);
                sent++;
            end else begin
                nwords = ($urandom_range(9) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(1, 4);
                tail = 4'($urandom_range(8));
                len = ($urandom_range(3) == 0) ? $urandom : 32'((nwords - 1) * 8 + tail);
                for (k = 0; k < nwords; k++) begin
                    it = make_word(rand64(), (k == nwords - 1) ? tail : 4'd8,
                                   (k == 0) ? len : $urandom, k == 0, k == nwords - 1);
                    send_word(it);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        #5ms;
        $display("fasthash64_stream: mismatch");
        $finish;
    end

    initial begin
        int unsigned n;
        sb = new();
        idle_pct = 15;
        seed_plan[0] = 64'h0;
        seed_plan[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        seed_plan[2] = rand64();
        seed_plan[3] = 64'h0000_0000_FFFF_FFFF;
        seed_plan[4] = 64'hFFFF_FFFF_0000_0000;
        seed_plan[5] = rand64();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_out_ready <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // continue from the cleared state without a first word
        send_word(make_word(rand64(), 4'd8, 32'd0, 1'b0, 1'b1));
        send_word(make_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd8, 1'b1, 1'b1));
        send_word(make_word(64'h0, 4'd0, 32'd0, 1'b1, 1'b1));
        send_word(make_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 32'hFFFF_FFFF, 1'b1, 1'b1));
        for (n = 1; n < 7; n++) begin
            send_word(make_word(64'hFFFF_FFFF_FFFF_FFFF, 4'(n), 32'(n), 1'b1, 1'b1));
        end
        send_word(make_word(64'hAAAA_AAAA_AAAA_AAAA, 4'd9, 32'd8, 1'b1, 1'b1));
        send_word(make_word(64'h5555_5555_5555_5555, 4'd12, 32'd8, 1'b1, 1'b1));
        send_word(make_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd8, 1'b1, 1'b1));
        send_word(make_word(rand64(), 4'd8, 32'd19, 1'b1, 1'b0));
        send_word(make_word(rand64(), 4'd0, 32'd0, 1'b0, 1'b0));
        send_word(make_word(rand64(), 4'd8, 32'd0, 1'b0, 1'b0));
        send_word(make_word(rand64(), 4'd3, 32'd0, 1'b0, 1'b1));
        send_word(make_word(rand64(), 4'd8, 32'd0, 1'b0, 1'b1));
        send_word(make_word(rand64(), 4'd8, 32'd8, 1'b1, 1'b0));
        send_word(make_word(rand64(), 4'd0, 32'd5, 1'b0, 1'b1));

        for (n = 0; n < 6; n++) begin
            write_seed(seed_plan[n]);
            idle_pct = (n == 1) ? 0 : 15;
            hash_random_messages(125);
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (sb.fault_count == 0 && sb.pending() == 0) begin
            $display("fasthash64_stream: match");
        end else begin
            $display("fasthash64_stream: mismatch");
        end
        $finish;
    end

endmodule
